[rtl/tste_pkg.sv]
// shared types, register indexes and divide helper for the tinted shade table entry block
`timescale 1ns / 1ps
`default_nettype none
package tste_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TINT_COLOR       = 3'd0,
    REG_RED_UP_SHIFT     = 3'd1,
    REG_GREEN_UP_SHIFT   = 3'd2,
    REG_RED_DOWN_SHIFT   = 3'd3,
    REG_GREEN_DOWN_SHIFT = 3'd4,
    REG_BLUE_DOWN_SHIFT  = 3'd5
  } cfg_reg_e;

  localparam logic [3:0]  LevelMax  = 4'hf;
  // 2^15 / 15 rounded up, exact for dividends below 4681
  localparam logic [11:0] Recip15   = 12'h889;
  localparam int unsigned Recip15Sh = 15;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } tint_t;

  // truncating divide by 15 for values up to 15*255
  function automatic logic [7:0] div15(input logic [11:0] x);
    logic [23:0] prod;
    prod = x * Recip15;
    return prod[Recip15Sh +: 8];
  endfunction

endpackage
`default_nettype wire

[rtl/tste_channel.sv]
// one color channel: scaled nibble in the high half plus scaled tint, wrapped to 8 bits
`timescale 1ns / 1ps
`default_nettype none
module tste_channel
  import tste_pkg::*;
(
  input  logic [3:0] nib_i,
  input  logic [7:0] tint_i,
  input  logic [3:0] level_i,
  output logic [7:0] shade_o
);

  logic [11:0] nib_prod;
  logic [11:0] tint_prod;
  logic [7:0]  nib_scaled;
  logic [7:0]  tint_scaled;

  assign nib_prod    = 12'(nib_i * level_i);
  assign tint_prod   = 12'(tint_i * level_i);
  assign nib_scaled  = div15(nib_prod);
  assign tint_scaled = div15(tint_prod);
  // nibble result is at most 15 so its shifted form fits the byte
  assign shade_o     = {nib_scaled[3:0], 4'h0} + tint_scaled;

endmodule
`default_nettype wire

[rtl/tinted_shade_table_entry_core.sv]
// top level of the tinted shade table entry generator
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   An index beat is taken on a rising edge with start high and busy low.
//   busy is tied low: a new index may be issued every cycle.
//   The index is registered, the three channels are shaded, placed and ORed,
//   and the packed entry appears on entry_value_o with done_o high for exactly
//   one cycle, driven from the result register.
//   Throughput is one entry per cycle; the input register and the result
//   register lie around the shading logic.
//   The receiver cannot stall: each result beat is valid for one cycle only.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (tint color,
//   red/green up shifts, red/green/blue down shifts); indexes past the list are
//   dropped. Write only while no index is in flight.
//   Reset clears the pipeline valid bits and loads tint 0, up shifts 10 and 5,
//   and down shifts 3.
module tinted_shade_table_entry_core
  import tste_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        entry_index_i,
  output logic               done_o,
  output logic [15:0]        entry_value_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);

  tint_t      tint_q;
  logic [3:0] red_up_q, green_up_q;
  logic [2:0] red_dn_q, green_dn_q, blue_dn_q;

  logic        in_vld_q;
  logic [15:0] idx_q;
  logic        out_vld_q;
  logic [15:0] value_q, value_d;

  logic [3:0]  level;
  logic [7:0]  red_shade, green_shade, blue_shade;
  logic [15:0] red_field, green_field, blue_field;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q     <= '0;
      red_up_q   <= 4'd10;
      green_up_q <= 4'd5;
      red_dn_q   <= 3'd3;
      green_dn_q <= 3'd3;
      blue_dn_q  <= 3'd3;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TINT_COLOR:       tint_q     <= tint_t'(cfg_data_i);
        REG_RED_UP_SHIFT:     red_up_q   <= cfg_data_i[3:0];
        REG_GREEN_UP_SHIFT:   green_up_q <= cfg_data_i[3:0];
        REG_RED_DOWN_SHIFT:   red_dn_q   <= cfg_data_i[2:0];
        REG_GREEN_DOWN_SHIFT: green_dn_q <= cfg_data_i[2:0];
        REG_BLUE_DOWN_SHIFT:  blue_dn_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= entry_index_i;
    value_q <= value_d;
  end

  assign level = LevelMax - idx_q[15:12];

  tste_channel u_red (
    .nib_i   (idx_q[11:8]),
    .tint_i  (tint_q.red),
    .level_i (level),
    .shade_o (red_shade)
  );

  tste_channel u_green (
    .nib_i   (idx_q[7:4]),
    .tint_i  (tint_q.green),
    .level_i (level),
    .shade_o (green_shade)
  );

  tste_channel u_blue (
    .nib_i   (idx_q[3:0]),
    .tint_i  (tint_q.blue),
    .level_i (level),
    .shade_o (blue_shade)
  );

  // bits pushed above 15 by the up shift are dropped
  assign red_field   = 16'({8'h00, red_shade} >> red_dn_q) << red_up_q;
  assign green_field = 16'({8'h00, green_shade} >> green_dn_q) << green_up_q;
  assign blue_field  = {8'h00, blue_shade} >> blue_dn_q;
  assign value_d     = red_field | green_field | blue_field;

  assign done_o        = out_vld_q;
  assign entry_value_o = value_q;

`ifndef NO_ASSERTIONS
  a_two_cycle_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 done_o)
    else $error("accepted index gave no result two cycles later");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> $past(start))
    else $error("pipeline valid without an accepted index");

  a_zero_level_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && entry_index_i[15:12] == 4'hf) |=> ##1 (entry_value_o == 16'h0000))
    else $error("zero level entry is not black");
`endif

endmodule
`default_nettype wire
